// ----- rtl/vct_pkg.sv -----
// ----------------------------------------------------------------------------
// vct_pkg
// Shared constants, register codes and transfer records of the viscous
// cohesive traction block.
// ----------------------------------------------------------------------------
package vct_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELD_BITS    = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 31;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PEAK_STRESS     = 3'd0,
        REG_NORMAL_LENGTH   = 3'd1,
        REG_TANGENT_LENGTH  = 3'd2,
        REG_PEAK_ONSET      = 3'd3,
        REG_SOFTENING_ONSET = 3'd4,
        REG_DAMPING         = 3'd5,
        REG_PENALTY_FACTOR  = 3'd6,
        REG_STEP_SIZE       = 3'd7
    } cfg_reg_t;

    localparam logic [30:0] RST_PEAK_STRESS     = 31'd65536;
    localparam logic [30:0] RST_NORMAL_LENGTH   = 31'd65536;
    localparam logic [30:0] RST_TANGENT_LENGTH  = 31'd65536;
    localparam logic [16:0] RST_PEAK_ONSET      = 17'd6554;
    localparam logic [15:0] RST_SOFTENING_ONSET = 16'd39322;
    localparam logic [30:0] RST_DAMPING         = 31'd0;
    localparam logic [30:0] RST_PENALTY_FACTOR  = 31'd65536;
    localparam logic [30:0] RST_STEP_SIZE       = 31'd65536;

    // configuration bundle, raw register widths
    typedef struct packed {
        logic [30:0] peak_stress;
        logic [30:0] normal_length;
        logic [30:0] tangent_length;
        logic [16:0] peak_onset;
        logic [15:0] softening_onset;
        logic [30:0] damping;
        logic [30:0] penalty_factor;
        logic [30:0] step_size;
    } vct_cfg_t;

    // fields that leave the block as chosen by the front end
    typedef struct packed {
        logic [FIELD_BITS-1:0] heat_in;
        logic [FIELD_BITS-1:0] next_saved_t;
        logic [FIELD_BITS-1:0] next_saved_n;
        logic [FIELD_BITS-1:0] next_older_t;
        logic [FIELD_BITS-1:0] next_older_n;
    } vct_pass_t;

    // classified item, front end to queue to back end
    typedef struct packed {
        logic [FIELD_BITS-1:0] jump_t;
        logic [FIELD_BITS-1:0] jump_n;
        logic [FIELD_BITS-1:0] ref_t;
        logic [FIELD_BITS-1:0] ref_n;
        logic                  integrate;
        vct_pass_t             pass;
    } vct_item_t;

endpackage

// ----- rtl/vct_dly.sv -----
// ----------------------------------------------------------------------------
// vct_dly
// Stallable delay line with a valid lane, keeps records aligned to units.
// ----------------------------------------------------------------------------
module vct_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             vld_reg [DEPTH];
    logic [WIDTH-1:0] dat_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
            begin
                dat_reg[i] <= dat_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = dat_reg[DEPTH-1];

endmodule

// ----- rtl/vct_div.sv -----
// ----------------------------------------------------------------------------
// vct_div
// Pipelined saturating fixed-point divider, (a * 2^F) / b toward zero,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module vct_div #(
    parameter int WORD_BITS = vct_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = vct_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic signed [WORD_BITS-1:0] q
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;
    localparam int SW = 2 * W + F;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [W-1:0]  ua;
    logic [W-1:0]  ub;
    logic [NW-1:0] num;
    logic          ovf0;

    logic [W:0]   r_reg   [W];
    logic [W-2:0] q_reg   [W];
    logic [W-2:0] lo_reg  [W];
    logic [W-1:0] ub_reg  [W];
    logic         neg_reg [W];
    logic         za_reg  [W];
    logic         ov_reg  [W];

    assign ua   = mag(a);
    assign ub   = mag(b);
    assign num  = {ua, {F{1'b0}}};
    // quotient reaching 2^(W-1) saturates; zero divisor lands here too
    assign ovf0 = (ub == '0) ||
                  ({{(SW-NW){1'b0}}, num} >= ({{(SW-W){1'b0}}, ub} << (W-1)));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= (W+1)'(num >> (W-1));
            q_reg[0]   <= '0;
            lo_reg[0]  <= num[W-2:0];
            ub_reg[0]  <= ub;
            neg_reg[0] <= a[W-1] ^ b[W-1];
            za_reg[0]  <= (ua == '0);
            ov_reg[0]  <= ovf0;
        end
    end

    for (genvar k = 1; k < W; k++)
    begin : g_stage
        logic [W:0]   t;
        logic         ge;
        logic [W-2:0] q_next;

        always_comb
        begin
            t         = {r_reg[k-1][W-1:0], lo_reg[k-1][W-1-k]};
            ge        = (t >= {1'b0, ub_reg[k-1]});
            q_next    = q_reg[k-1];
            q_next[W-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? (t - {1'b0, ub_reg[k-1]}) : t;
                q_reg[k]   <= q_next;
                lo_reg[k]  <= lo_reg[k-1];
                ub_reg[k]  <= ub_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                za_reg[k]  <= za_reg[k-1];
                ov_reg[k]  <= ov_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (za_reg[W-1])
        begin
            q = '0;
        end
        else if (neg_reg[W-1])
        begin
            q = ov_reg[W-1] ? {1'b1, {(W-1){1'b0}}} : -$signed({1'b0, q_reg[W-1]});
        end
        else
        begin
            q = ov_reg[W-1] ? {1'b0, {(W-1){1'b1}}} : $signed({1'b0, q_reg[W-1]});
        end
    end

endmodule

// ----- rtl/vct_sqrt.sv -----
// ----------------------------------------------------------------------------
// vct_sqrt
// Pipelined floor square root of a 2F-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module vct_sqrt #(
    parameter int FRAC_BITS = vct_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*FRAC_BITS-1:0]   s,
    output logic [FRAC_BITS-1:0]     root
);

    localparam int F = FRAC_BITS;

    logic [F-1:0]   x_reg   [F];
    logic [2*F-1:0] rem_reg [F];

    for (genvar k = 0; k < F; k++)
    begin : g_stage
        localparam int J = F - 1 - k;
        logic [F-1:0]   px;
        logic [2*F-1:0] prem;
        logic [2*F:0]   inc;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign px   = '0;
            assign prem = s;
        end
        else
        begin : g_next
            assign px   = x_reg[k-1];
            assign prem = rem_reg[k-1];
        end

        // (x + 2^J)^2 - x^2
        assign inc = ({{(F+1){1'b0}}, px} << (J+1)) + ((2*F+1)'(1) << (2*J));
        assign ge  = ({1'b0, prem} >= inc);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (2*F)'({1'b0, prem} - inc) : prem;
                x_reg[k]   <= ge ? (px | (F'(1) << J)) : px;
            end
        end
    end

    assign root = x_reg[F-1];

endmodule

// ----- rtl/vct_fifo.sv -----
// ----------------------------------------------------------------------------
// vct_fifo
// Short register queue between front end and back end.
// ----------------------------------------------------------------------------
module vct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vct_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/vct_front.sv -----
// ----------------------------------------------------------------------------
// vct_front
// Input stage: clips fields to the word, picks the increment reference and
// the saved-value outputs from the integrate flag, hands items to the queue.
// ----------------------------------------------------------------------------
module vct_front #(
    parameter int WORD_BITS = vct_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         jump_t,
    input  logic [31:0]         jump_n,
    input  logic [31:0]         saved_t,
    input  logic [31:0]         saved_n,
    input  logic [31:0]         older_t,
    input  logic [31:0]         older_n,
    input  logic [31:0]         heat_in,
    input  logic                integrate,
    output logic                push,
    input  logic                full,
    output vct_pkg::vct_item_t  item
);

    localparam longint WMAXL = (WORD_BITS >= 64) ? 64'sh7FFF_FFFF_FFFF_FFFF :
                               ((longint'(1) <<< (WORD_BITS - 1)) - 1);
    localparam longint WMINL = -WMAXL - 1;

    function automatic logic [31:0] clipw(input logic [31:0] x);
        longint v;
        v = longint'(signed'(x));
        if (v > WMAXL)
        begin
            v = WMAXL;
        end
        else if (v < WMINL)
        begin
            v = WMINL;
        end
        return v[31:0];
    endfunction

    logic               vld_reg;
    vct_pkg::vct_item_t item_reg;
    vct_pkg::vct_item_t item_next;
    logic [31:0]        ct, cn, st, sn, ot, on;

    assign in_ready = !vld_reg || !full;
    assign push     = vld_reg && !full;
    assign item     = item_reg;

    always_comb
    begin
        ct = clipw(jump_t);
        cn = clipw(jump_n);
        st = clipw(saved_t);
        sn = clipw(saved_n);
        ot = clipw(older_t);
        on = clipw(older_n);
        item_next.jump_t            = ct;
        item_next.jump_n            = cn;
        item_next.integrate         = integrate;
        item_next.ref_t             = integrate ? st : ot;
        item_next.ref_n             = integrate ? sn : on;
        item_next.pass.heat_in      = clipw(heat_in);
        item_next.pass.next_saved_t = integrate ? ct : st;
        item_next.pass.next_saved_n = integrate ? cn : sn;
        item_next.pass.next_older_t = integrate ? st : ot;
        item_next.pass.next_older_n = integrate ? sn : on;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/vct_back.sv -----
// ----------------------------------------------------------------------------
// vct_back
// Arithmetic pipeline: ratios, normalized opening, region traction,
// penalty, viscous damping and heat; one output register at the end.
// ----------------------------------------------------------------------------
module vct_back #(
    parameter int WORD_BITS = vct_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = vct_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vct_pkg::vct_cfg_t   cfg,
    input  logic                q_valid,
    input  vct_pkg::vct_item_t  q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [223:0]        out_data
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam longint WMAXL = (W >= 64) ? 64'sh7FFF_FFFF_FFFF_FFFF :
                               ((longint'(1) <<< (W - 1)) - 1);

    typedef logic signed [W-1:0] sw_t;

    localparam sw_t ONE_Q  = W'(longint'(1) <<< F);
    localparam sw_t HEAT_Q = W'(((longint'(9) <<< F) + 5) / 10);
    localparam sw_t SMAX   = {1'b0, {(W-1){1'b1}}};
    localparam sw_t SMIN   = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        sw_t ut, un, ddt, ddn;
        sw_t rt, rn, c1, rnd, tnpen;
        sw_t lv, sigb, vt, vn, sig, tt, tn;
        sw_t trt, trn, p1, p2, p3, p4, d;
        logic integ;
        logic big;
        vct_pkg::vct_pass_t pass;
    } rec_t;

    function automatic logic [W-1:0] mag(input sw_t x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic sw_t from_mag(input logic neg, input logic [W-1:0] m,
                                     input logic ovf);
        sw_t r;
        if (neg)
        begin
            r = (ovf || m[W-1]) ? SMIN : sw_t'(~m + 1'b1);
        end
        else
        begin
            r = (ovf || m[W-1]) ? SMAX : sw_t'(m);
        end
        return r;
    endfunction

    function automatic sw_t mul_q(input sw_t a, input sw_t b);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, mag(a)} * {{W{1'b0}}, mag(b)};
        return from_mag(a[W-1] ^ b[W-1], p[W+F-1:F], |p[2*W-1:W+F]);
    endfunction

    function automatic sw_t add_s(input sw_t a, input sw_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? SMIN : SMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic sw_t sub_s(input sw_t a, input sw_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? SMIN : SMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic sw_t cfgw(input logic [30:0] v);
        longint t;
        t = longint'({33'd0, v});
        if (t > WMAXL)
        begin
            t = WMAXL;
        end
        return W'(t);
    endfunction

    function automatic logic [31:0] to32(input sw_t x);
        return 32'(x);
    endfunction

    // configuration in word format
    sw_t pk, dn, dtl, l1, l2, eta0, pen, ts;
    assign pk   = cfgw(cfg.peak_stress);
    assign dn   = cfgw(cfg.normal_length);
    assign dtl  = cfgw(cfg.tangent_length);
    assign l1   = cfgw({14'd0, cfg.peak_onset});
    assign l2   = cfgw({15'd0, cfg.softening_onset});
    assign eta0 = cfgw(cfg.damping);
    assign pen  = cfgw(cfg.penalty_factor);
    assign ts   = cfgw(cfg.step_size);

    logic en;
    logic out_valid_reg;
    logic [223:0] out_data_reg;

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---- entry stage: increments, penalty stiffness products
    rec_t rec0_next, rec0_reg;
    logic v0_reg;
    sw_t  mpk_reg, ml_reg;

    always_comb
    begin
        rec0_next       = '0;
        rec0_next.ut    = W'(signed'(q_item.jump_t));
        rec0_next.un    = W'(signed'(q_item.jump_n));
        rec0_next.ddt   = sub_s(W'(signed'(q_item.jump_t)), W'(signed'(q_item.ref_t)));
        rec0_next.ddn   = sub_s(W'(signed'(q_item.jump_n)), W'(signed'(q_item.ref_n)));
        rec0_next.integ = q_item.integrate;
        rec0_next.pass  = q_item.pass;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec0_reg <= rec0_next;
            mpk_reg  <= mul_q(pen, pk);
            ml_reg   <= mul_q(l1, dn);
        end
    end

    // ---- first divider bank
    sw_t  q_rt, q_rn, q_c1, q_rnd, q_kp;
    rec_t rec1;
    logic v1;

    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_rt
        (.clk(clk), .en(en), .a(rec0_reg.ut), .b(dtl), .q(q_rt));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_rn
        (.clk(clk), .en(en), .a(rec0_reg.un), .b(dn), .q(q_rn));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_c1
        (.clk(clk), .en(en), .a(pk), .b(l1), .q(q_c1));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_rnd
        (.clk(clk), .en(en), .a(dn), .b(dtl), .q(q_rnd));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_kp
        (.clk(clk), .en(en), .a(mpk_reg), .b(ml_reg), .q(q_kp));
    vct_dly #(.WIDTH($bits(rec_t)), .DEPTH(W)) u_dly1
        (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(v0_reg), .in_data(rec0_reg),
         .out_valid(v1), .out_data(rec1));

    // ---- squares of the ratios
    rec_t rec2_reg, rec2_next, rec2_fix;
    logic v2_reg;
    logic [2*F-1:0] sqa_reg, sqb_reg;
    logic [W-1:0] mt, mn;
    logic [2*F:0] ssum;

    assign mt = mag(q_rt);
    assign mn = mag(q_rn);

    always_comb
    begin
        rec2_next       = rec1;
        rec2_next.rt    = q_rt;
        rec2_next.rn    = q_rn;
        rec2_next.c1    = q_c1;
        rec2_next.rnd   = q_rnd;
        rec2_next.tnpen = mul_q(q_kp, rec1.un);
        rec2_next.big   = (|mt[W-1:F]) || (|mn[W-1:F]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec2_reg <= rec2_next;
            sqa_reg  <= mt[F-1:0] * mt[F-1:0];
            sqb_reg  <= mn[F-1:0] * mn[F-1:0];
        end
    end

    assign ssum = {1'b0, sqa_reg} + {1'b0, sqb_reg};

    always_comb
    begin
        rec2_fix     = rec2_reg;
        rec2_fix.big = rec2_reg.big || ssum[2*F];
    end

    // ---- normalized opening
    logic [F-1:0] root;
    rec_t rec3;
    logic v3;

    vct_sqrt #(.FRAC_BITS(F)) u_sqrt
        (.clk(clk), .en(en), .s(ssum[2*F-1:0]), .root(root));
    vct_dly #(.WIDTH($bits(rec_t)), .DEPTH(F)) u_dly3
        (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2_reg), .in_data(rec2_fix),
         .out_valid(v3), .out_data(rec3));

    sw_t  lv;
    rec_t rec4_reg, rec4_next;
    logic v4_reg;
    sw_t  fa_reg, fb_reg, meta_reg;

    assign lv = rec3.big ? ONE_Q : sw_t'({{(W-F){1'b0}}, root});

    always_comb
    begin
        rec4_next    = rec3;
        rec4_next.lv = lv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec4_reg <= rec4_next;
            fa_reg   <= sub_s(lv, l2);
            fb_reg   <= sub_s(ONE_Q, l2);
            meta_reg <= mul_q(eta0, sub_s(ONE_Q, lv));
        end
    end

    // ---- second divider bank: softening fraction, pk/L, eta/dt
    sw_t  q_fr, q_pl, q_eta;
    rec_t rec5;
    logic v5;

    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_fr
        (.clk(clk), .en(en), .a(fa_reg), .b(fb_reg), .q(q_fr));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_pl
        (.clk(clk), .en(en), .a(pk), .b(rec4_reg.lv), .q(q_pl));
    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_eta
        (.clk(clk), .en(en), .a(meta_reg), .b(ts), .q(q_eta));
    vct_dly #(.WIDTH($bits(rec_t)), .DEPTH(W)) u_dly5
        (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg), .in_data(rec4_reg),
         .out_valid(v5), .out_data(rec5));

    rec_t rec6_reg, rec6_next;
    logic v6_reg;
    sw_t  mfr_reg;
    logic eta_on;

    // viscosity only below failure and with a nonzero step
    assign eta_on = (rec5.lv < ONE_Q) && (ts != '0);

    always_comb
    begin
        rec6_next      = rec5;
        rec6_next.sigb = q_pl;
        rec6_next.vt   = eta_on ? mul_q(q_eta, rec5.ddt) : '0;
        rec6_next.vn   = eta_on ? mul_q(q_eta, rec5.ddn) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec6_reg <= rec6_next;
            mfr_reg  <= mul_q(pk, sub_s(ONE_Q, q_fr));
        end
    end

    // ---- third divider: softening traction over L
    sw_t  q_sf;
    rec_t rec7;
    logic v7;

    vct_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_sf
        (.clk(clk), .en(en), .a(mfr_reg), .b(rec6_reg.lv), .q(q_sf));
    vct_dly #(.WIDTH($bits(rec_t)), .DEPTH(W)) u_dly7
        (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(v6_reg), .in_data(rec6_reg),
         .out_valid(v7), .out_data(rec7));

    // ---- tail: region select, tractions, heat
    rec_t stg_reg  [8:14];
    rec_t stg_next [8:14];
    logic sv_reg  [8:14];
    logic [223:0] out_next;
    sw_t  heat_w;
    logic same_sign;

    assign same_sign = ((stg_reg[13].ut > 0) && (stg_reg[13].ddt > 0)) ||
                       ((stg_reg[13].ut < 0) && (stg_reg[13].ddt < 0));

    always_comb
    begin
        stg_next[8] = rec7;
        if (rec7.lv < l1)
        begin
            stg_next[8].sig = rec7.c1;
        end
        else if (rec7.lv < l2)
        begin
            stg_next[8].sig = rec7.sigb;
        end
        else if (rec7.lv < ONE_Q)
        begin
            stg_next[8].sig = q_sf;
        end
        else
        begin
            stg_next[8].sig = '0;
        end

        stg_next[9]    = stg_reg[8];
        stg_next[9].tt = mul_q(stg_reg[8].sig, stg_reg[8].rt);
        stg_next[9].tn = mul_q(stg_reg[8].sig, stg_reg[8].rn);

        // penetration adds the penalty term
        stg_next[10]    = stg_reg[9];
        stg_next[10].tt = mul_q(stg_reg[9].tt, stg_reg[9].rnd);
        stg_next[10].tn = stg_reg[9].un[W-1] ? add_s(stg_reg[9].tn, stg_reg[9].tnpen)
                                             : stg_reg[9].tn;

        stg_next[11]     = stg_reg[10];
        stg_next[11].trt = add_s(stg_reg[10].tt, stg_reg[10].vt);
        stg_next[11].trn = add_s(stg_reg[10].tn, stg_reg[10].vn);
        stg_next[11].p1  = mul_q(stg_reg[10].vt, stg_reg[10].ddt);
        stg_next[11].p2  = mul_q(stg_reg[10].vn, stg_reg[10].ddn);
        stg_next[11].p3  = mul_q(stg_reg[10].tn, stg_reg[10].ddn);
        stg_next[11].p4  = mul_q(stg_reg[10].tt, stg_reg[10].ddt);

        stg_next[12]   = stg_reg[11];
        stg_next[12].d = add_s(stg_reg[11].p1, stg_reg[11].p2);

        // normal work only on opening
        stg_next[13]   = stg_reg[12];
        stg_next[13].d = (stg_reg[12].ddn > 0) ? add_s(stg_reg[12].d, stg_reg[12].p3)
                                               : stg_reg[12].d;

        // tangential work as a magnitude when jump and increment agree
        stg_next[14]   = stg_reg[13];
        stg_next[14].d = same_sign ?
                         add_s(stg_reg[13].d, from_mag(1'b0, mag(stg_reg[13].p4), 1'b0))
                         : stg_reg[13].d;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 8; i <= 14; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign heat_w = mul_q(HEAT_Q, stg_reg[14].d);

    always_comb
    begin
        out_next = {stg_reg[14].pass.next_older_n,
                    stg_reg[14].pass.next_older_t,
                    stg_reg[14].pass.next_saved_n,
                    stg_reg[14].pass.next_saved_t,
                    stg_reg[14].integ ? to32(heat_w) : stg_reg[14].pass.heat_in,
                    to32(stg_reg[14].trn),
                    to32(stg_reg[14].trt)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            for (int i = 8; i <= 14; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= q_valid;
            v2_reg        <= v1;
            v4_reg        <= v3;
            v6_reg        <= v5;
            sv_reg[8]     <= v7;
            for (int i = 9; i <= 14; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
            out_valid_reg <= sv_reg[14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

// ----- rtl/viscous_cohesive_traction.sv -----
// ----------------------------------------------------------------------------
// viscous_cohesive_traction
// Trapezoidal cohesive traction law with penetration penalty, viscous
// damping and dissipated heat, one integration point per transfer.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                   handshake
//  s_axis    in         7 x 32b opening/saved/heat, integrate     tvalid/tready
//  m_axis    out        7 x 32b tractions, heat, saved openings   tvalid/tready
//  cfg       in         3b register index, 31b data               valid/ready
//
//  Throughput: one transfer per cycle on both streams while m_axis is not stalled.
//  From input transfer to result valid the path runs through the three chained
//  bit-per-stage divider banks and the root stages (Q16.16 by default).
//  Input stage and a 4-entry queue sit ahead of the arithmetic pipeline, so
//  input keeps flowing for a few transfers while a result waits.
//  A stall on m_axis freezes the whole arithmetic pipeline; the queue fills.
//  Reset clears control only; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module viscous_cohesive_traction #(
    parameter int WORD_BITS = vct_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = vct_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // jump_t, jump_n, saved_t, saved_n, older_t, older_n, heat_in (32b each)
    input  logic [223:0] s_axis_tdata,
    // integrate
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // traction_t, traction_n, heat_out, next_saved_t, next_saved_n,
    // next_older_t, next_older_n (32b each)
    output logic [223:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    // configuration registers; writes are always taken
    vct_pkg::vct_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_stress     <= vct_pkg::RST_PEAK_STRESS;
            cfg_reg.normal_length   <= vct_pkg::RST_NORMAL_LENGTH;
            cfg_reg.tangent_length  <= vct_pkg::RST_TANGENT_LENGTH;
            cfg_reg.peak_onset      <= vct_pkg::RST_PEAK_ONSET;
            cfg_reg.softening_onset <= vct_pkg::RST_SOFTENING_ONSET;
            cfg_reg.damping         <= vct_pkg::RST_DAMPING;
            cfg_reg.penalty_factor  <= vct_pkg::RST_PENALTY_FACTOR;
            cfg_reg.step_size       <= vct_pkg::RST_STEP_SIZE;
        end
        else if (cfg_valid)
        begin
            unique case (vct_pkg::cfg_reg_t'(cfg_index))
                vct_pkg::REG_PEAK_STRESS:     cfg_reg.peak_stress     <= cfg_data;
                vct_pkg::REG_NORMAL_LENGTH:   cfg_reg.normal_length   <= cfg_data;
                vct_pkg::REG_TANGENT_LENGTH:  cfg_reg.tangent_length  <= cfg_data;
                vct_pkg::REG_PEAK_ONSET:      cfg_reg.peak_onset      <= cfg_data[16:0];
                vct_pkg::REG_SOFTENING_ONSET: cfg_reg.softening_onset <= cfg_data[15:0];
                vct_pkg::REG_DAMPING:         cfg_reg.damping         <= cfg_data;
                vct_pkg::REG_PENALTY_FACTOR:  cfg_reg.penalty_factor  <= cfg_data;
                vct_pkg::REG_STEP_SIZE:       cfg_reg.step_size       <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // front end: clip and classify
    logic               push;
    logic               full;
    vct_pkg::vct_item_t front_item;

    vct_front #(.WORD_BITS(WORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .jump_t    (s_axis_tdata[31:0]),
        .jump_n    (s_axis_tdata[63:32]),
        .saved_t   (s_axis_tdata[95:64]),
        .saved_n   (s_axis_tdata[127:96]),
        .older_t   (s_axis_tdata[159:128]),
        .older_n   (s_axis_tdata[191:160]),
        .heat_in   (s_axis_tdata[223:192]),
        .integrate (s_axis_tuser[0]),
        .push      (push),
        .full      (full),
        .item      (front_item)
    );

    // decoupling queue
    logic               pop;
    logic               q_valid;
    vct_pkg::vct_item_t q_item;

    vct_fifo #(
        .WIDTH ($bits(vct_pkg::vct_item_t)),
        .DEPTH (vct_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (front_item),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .rdata     (q_item)
    );

    // back end: arithmetic pipeline and output register
    vct_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/vct_chk.sv -----
// ----------------------------------------------------------------------------
// vct_chk
// Port-level checks of the viscous cohesive traction block.
// ----------------------------------------------------------------------------
module vct_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata,
    input logic         cfg_ready
);

    logic [15:0] inflight_reg;
    logic        s_xfer;
    logic        m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 16'(s_xfer) - 16'(m_xfer);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer |-> inflight_reg != '0)
        else $error("result without an accepted item");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 && !m_axis_tvalid |-> s_axis_tready)
        else $error("empty block refuses input");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind viscous_cohesive_traction vct_chk u_vct_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

// ----- dv/viscous_cohesive_traction_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// viscous_cohesive_traction_test
// Streams integration points through the cohesive traction block under
// several register settings and random stalls on both streams. Every result
// is checked field by field against a fixed-point prediction of the law.
// ----------------------------------------------------------------------------
module viscous_cohesive_traction_test;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam longint HEAT_GAIN = 64'sd58982;    // round(0.9 * 2^16)
    localparam int PHASE_ITEMS = 64;

    // ------------------------------------------------------------------
    // expected results of the traction law, oldest first
    // ------------------------------------------------------------------
    class traction_scoreboard;
        longint cfg_val[8];
        logic [223:0] expected_q[$];
        int errors;

        function new();
            cfg_val[vct_pkg::REG_PEAK_STRESS]     = vct_pkg::RST_PEAK_STRESS;
            cfg_val[vct_pkg::REG_NORMAL_LENGTH]   = vct_pkg::RST_NORMAL_LENGTH;
            cfg_val[vct_pkg::REG_TANGENT_LENGTH]  = vct_pkg::RST_TANGENT_LENGTH;
            cfg_val[vct_pkg::REG_PEAK_ONSET]      = vct_pkg::RST_PEAK_ONSET;
            cfg_val[vct_pkg::REG_SOFTENING_ONSET] = vct_pkg::RST_SOFTENING_ONSET;
            cfg_val[vct_pkg::REG_DAMPING]         = vct_pkg::RST_DAMPING;
            cfg_val[vct_pkg::REG_PENALTY_FACTOR]  = vct_pkg::RST_PENALTY_FACTOR;
            cfg_val[vct_pkg::REG_STEP_SIZE]       = vct_pkg::RST_STEP_SIZE;
            errors = 0;
        endfunction

        function void set_reg(vct_pkg::cfg_reg_t idx, longint value);
            cfg_val[idx] = value;
        endfunction

        function longint clamp(longint x);
            return x > WMAX ? WMAX : (x < WMIN ? WMIN : x);
        endfunction

        function longint from_mag(bit neg, longint m);
            if (neg)
                return m >= 64'sd2147483648 ? WMIN : -m;
            return m > WMAX ? WMAX : m;
        endfunction

        function longint qmul(longint a, longint b);
            longint ua;
            longint ub;
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            return from_mag((a < 0) != (b < 0), (ua * ub) >>> 16);
        endfunction

        function longint qdiv(longint a, longint b);
            longint ua;
            longint ub;
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            if (a == 0)
                return 0;
            if (b == 0)
                return a < 0 ? WMIN : WMAX;
            return from_mag((a < 0) != (b < 0), (ua <<< 16) / ub);
        endfunction

        // normalized opening, 1.0 once either ratio or the sum reaches it
        function longint opening(longint rt, longint rn);
            longint mt;
            longint mn;
            longint s;
            longint r;
            longint c;
            mt = rt < 0 ? -rt : rt;
            mn = rn < 0 ? -rn : rn;
            if (mt >= ONE_Q || mn >= ONE_Q)
                return ONE_Q;
            s = mt * mt + mn * mn;
            if (s >= 64'sd4294967296)
                return ONE_Q;
            r = 0;
            for (int i = 16; i >= 0; i--)
            begin
                c = r | (64'sd1 << i);
                if (c * c <= s)
                    r = c;
            end
            return r;
        endfunction

        function void note_point(logic [223:0] pt, bit integ);
            longint pk, dn, dtl, l1, l2, eta0, pen, ts;
            longint ut, un, st, sn, ot, on, heat;
            longint rt, rn, lval, sig, tt, tn, ddt, ddn, vt, vn, frac, kpen, eta_dt, d;
            longint res[7];
            logic [223:0] word;
            pk = cfg_val[vct_pkg::REG_PEAK_STRESS];
            dn = cfg_val[vct_pkg::REG_NORMAL_LENGTH];
            dtl = cfg_val[vct_pkg::REG_TANGENT_LENGTH];
            l1 = cfg_val[vct_pkg::REG_PEAK_ONSET];
            l2 = cfg_val[vct_pkg::REG_SOFTENING_ONSET];
            eta0 = cfg_val[vct_pkg::REG_DAMPING];
            pen = cfg_val[vct_pkg::REG_PENALTY_FACTOR];
            ts = cfg_val[vct_pkg::REG_STEP_SIZE];
            ut = longint'($signed(pt[31:0]));
            un = longint'($signed(pt[63:32]));
            st = longint'($signed(pt[95:64]));
            sn = longint'($signed(pt[127:96]));
            ot = longint'($signed(pt[159:128]));
            on = longint'($signed(pt[191:160]));
            heat = longint'($signed(pt[223:192]));
            vt = 0;
            vn = 0;
            rt = qdiv(ut, dtl);
            rn = qdiv(un, dn);
            lval = opening(rt, rn);
            // regions tested rise, plateau, softening: out-of-order onsets skip one
            if (lval < l1)
                sig = qdiv(pk, l1);
            else if (lval < l2)
                sig = qdiv(pk, lval);
            else if (lval < ONE_Q)
            begin
                frac = qdiv(clamp(lval - l2), clamp(ONE_Q - l2));
                sig = qdiv(qmul(pk, clamp(ONE_Q - frac)), lval);
            end
            else
                sig = 0;
            tt = qmul(qmul(sig, rt), qdiv(dn, dtl));
            tn = qmul(sig, rn);
            if (un < 0)
            begin
                kpen = qdiv(qmul(pen, pk), qmul(l1, dn));
                tn = clamp(tn + qmul(kpen, un));
            end
            // increment taken against saved openings only when integrating
            ddt = clamp(ut - (integ ? st : ot));
            ddn = clamp(un - (integ ? sn : on));
            if (lval < ONE_Q && ts != 0)
            begin
                eta_dt = qdiv(qmul(eta0, clamp(ONE_Q - lval)), ts);
                vt = qmul(eta_dt, ddt);
                vn = qmul(eta_dt, ddn);
            end
            if (integ)
            begin
                d = clamp(qmul(vt, ddt) + qmul(vn, ddn));
                if (ddn > 0)
                    d = clamp(d + qmul(tn, ddn));
                // tangential work counted as a magnitude when signs agree
                if ((ut > 0 && ddt > 0) || (ut < 0 && ddt < 0))
                    d = clamp(d + from_mag(1'b0, qmul(tt, ddt) < 0 ?
                                            -qmul(tt, ddt) : qmul(tt, ddt)));
                heat = qmul(HEAT_GAIN, d);
                res[3] = ut; res[4] = un; res[5] = st; res[6] = sn;
            end
            else
            begin
                res[3] = st; res[4] = sn; res[5] = ot; res[6] = on;
            end
            res[0] = clamp(tt + vt);
            res[1] = clamp(tn + vn);
            res[2] = heat;
            for (int k = 0; k < 7; k++)
                word[32*k +: 32] = res[k][31:0];
            expected_q.push_back(word);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [223:0] got);
            logic [223:0] want;
            string names[7];
            names = '{"traction_t", "traction_n", "heat_out", "next_saved_t",
                      "next_saved_n", "next_older_t", "next_older_n"};
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", got[31:0], 32'd0);
                return;
            end
            want = expected_q.pop_front();
            for (int k = 0; k < 7; k++)
                if (got[32*k +: 32] !== want[32*k +: 32])
                    report_mismatch(names[k], got[32*k +: 32], want[32*k +: 32]);
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;      // jump_t, jump_n, saved_t/n, older_t/n, heat_in
    logic [0:0]   s_axis_tuser;      // integrate
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [223:0] m_axis_tdata;      // tractions, heat_out, next saved and older
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;

    traction_scoreboard sb;
    bit calm;                        // no idling on either side while set
    longint shadow[8];               // register copy used to shape stimulus

    viscous_cohesive_traction i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // result side: check every transfer, stall at random unless calm
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end

    task write_reg(vct_pkg::cfg_reg_t idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[30:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
        shadow[idx] = value;
    endtask

    task set_all(longint pk, longint dn, longint dt, longint l1, longint l2,
                 longint eta, longint pen, longint ts);
        write_reg(vct_pkg::REG_PEAK_STRESS, pk);
        write_reg(vct_pkg::REG_NORMAL_LENGTH, dn);
        write_reg(vct_pkg::REG_TANGENT_LENGTH, dt);
        write_reg(vct_pkg::REG_PEAK_ONSET, l1);
        write_reg(vct_pkg::REG_SOFTENING_ONSET, l2);
        write_reg(vct_pkg::REG_DAMPING, eta);
        write_reg(vct_pkg::REG_PENALTY_FACTOR, pen);
        write_reg(vct_pkg::REG_STEP_SIZE, ts);
    endtask

    task send_point(logic [31:0] f[7], bit integ);
        if (!calm && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= integ;
        for (int k = 0; k < 7; k++)
            s_axis_tdata[32*k +: 32] <= f[k];
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_point({f[6], f[5], f[4], f[3], f[2], f[1], f[0]}, integ);
    endtask

    // mostly openings near the failure length so every region is hit
    function logic [31:0] opening_value(longint len);
        longint span;
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default:
            begin
                span = len > 64'sd1000000000 ? 64'sd1000000000 : len;
                return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
            end
        endcase
    endfunction

    task drain;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task random_phase;
        logic [31:0] f[7];
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            calm = (n >= 20 && n < 40);
            f[0] = opening_value(shadow[vct_pkg::REG_TANGENT_LENGTH]);
            f[1] = opening_value(shadow[vct_pkg::REG_NORMAL_LENGTH]);
            // saved and older openings near the present one, or anywhere
            for (int k = 2; k < 6; k++)
                f[k] = $urandom_range(2) == 0 ? $urandom
                       : f[k % 2] + 32'($signed($urandom_range(0, 8192)) - 4096);
            f[6] = $urandom;
            send_point(f, $urandom_range(1));
        end
        calm = 1'b0;
        drain();
    endtask

    task directed_phase;
        logic [31:0] f[7];
        logic [31:0] edges[6];
        edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                  32'h00010000, 32'hffff0000};
        for (int i = 0; i < 6; i++)
        begin
            f = '{edges[i], edges[5 - i], edges[(i + 1) % 6], edges[(i + 2) % 6],
                  edges[(i + 3) % 6], edges[(i + 4) % 6], edges[i]};
            send_point(f, 1'b1);
            send_point(f, 1'b0);
        end
        // plateau, softening and penetration with positive and negative increments
        f = '{32'h00008000, 32'h00004000, 32'h00001000, 32'h00002000,
              32'h0, 32'h0, 32'h12345678};
        send_point(f, 1'b1);
        f = '{32'hffff8000, 32'hffffc000, 32'h00001000, 32'h0,
              32'h0, 32'h0, 32'h0};
        send_point(f, 1'b1);
        f = '{32'h0000f000, 32'h00001000, 32'h00010000, 32'h0,
              32'h0, 32'h0, 32'h0};
        send_point(f, 1'b0);
        drain();
    endtask

    initial
    begin
        sb = new();
        for (int i = 0; i < 8; i++)
            shadow[i] = sb.cfg_val[i];
        clk = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = vct_pkg::REG_PEAK_STRESS;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_phase();
        random_phase();
        // typical with damping
        set_all(64'sd65536, 64'sd65536, 64'sd65536, 64'sd6554, 64'sd39322,
                64'sd32768, 64'sd65536, 64'sd65536);
        directed_phase();
        random_phase();
        // largest values everywhere
        set_all(WMAX, WMAX, WMAX, 64'sd65536, 64'sd65535, WMAX, WMAX, WMAX);
        random_phase();
        // smallest values, zero step turns viscosity off
        set_all(64'sd0, 64'sd1, 64'sd1, 64'sd1, 64'sd1, 64'sd0, 64'sd0, 64'sd0);
        directed_phase();
        random_phase();
        // onsets out of order, small step
        set_all(64'sd131072, 64'sd32768, 64'sd98304, 64'sd60000, 64'sd20000,
                64'sd200000, 64'sd300000, 64'sd1);
        random_phase();
        for (int p = 0; p < 5; p++)
        begin
            set_all($urandom_range(0, 32'h7fffffff), $urandom_range(1, 32'h7fffffff),
                    $urandom_range(1, 32'h0fffffff), $urandom_range(1, 65536),
                    $urandom_range(1, 65535), $urandom_range(0, 32'h7fffffff),
                    $urandom_range(0, 32'h7fffffff), $urandom_range(0, 32'h7fffffff));
            random_phase();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
